// ===== src/acl_rtm_pkg.sv =====
// shared constants, codes and beat layouts for the acl rule table manager
package acl_rtm_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int ADDR_KEY_W  = 64;
    localparam int RANGE_KEY_W = 44;
    localparam int KEY_W       = ADDR_KEY_W + RANGE_KEY_W;
    localparam int IN_W        = 120;
    localparam int OUT_W       = 24;

    typedef enum logic [1:0] {
        ACT_ADD       = 2'd0,
        ACT_DEL_MATCH = 2'd1,
        ACT_DEL_INDEX = 2'd2,
        ACT_CLEAR     = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_EXISTS    = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    // request beat, last field in the lowest bits
    typedef struct packed {
        logic [1:0]  pad;
        logic [7:0]  rule_index;
        logic [15:0] port_high;
        logic [15:0] port_low;
        logic [5:0]  dst_prefix;
        logic [31:0] dst_addr;
        logic [5:0]  src_prefix;
        logic [31:0] src_addr;
        t_action     action;
    } t_req;

    // response beat, last field in the lowest bits
    typedef struct packed {
        logic [3:0] pad;
        logic       uncommitted;
        logic [8:0] free_slots;
        logic [7:0] slot;
        t_status    status;
    } t_rsp;

endpackage

// ===== src/acl_rtm_ram.sv =====
// generic single-port-write, single-port-read ram with registered read data
module acl_rtm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

// ===== src/acl_rule_table_manager_top.sv =====
// top level of the acl rule table manager: rule table, scan engine and stream ports
//
// One request beat on the slave stream carries one action (add, delete by match,
// delete by index, clear) and produces exactly one response beat on the master
// stream with status, slot, free slot count and the uncommitted flag.
// Rule keys live in one ram of TABLE_DEPTH entries with registered read data;
// per-slot valid bits, the free count and the uncommitted flag are flip-flops.
// Add and delete by match walk the ram from slot 0 upward, one read per cycle,
// comparing each returned entry in the cycle after its read; a match ends the walk early.
// Delete by index, clear, an add to a full table or a delete on an empty one skip the
// walk. One request is worked on at a time, so a new request is not taken until the
// previous one has been put into the output register.
// o_s_tready is high whenever no request is in work; a new request is taken while
// the previous response still waits in the output register.
// A stalled receiver holds the response steady; the block finishes the current
// request and then waits until the output register frees up.
// Reset (i_rst_n low, synchronous) empties the table, restores the free count to
// TABLE_DEPTH, clears the uncommitted flag and drops any pending response.
// No clearing pass over the ram is needed: entries are only read behind valid bits.
module acl_rule_table_manager_top (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_s_tvalid,
    output logic                         o_s_tready,
    // action, src_addr, src_prefix, dst_addr, dst_prefix, port_low, port_high,
    // rule_index, zero pad
    input  logic [acl_rtm_pkg::IN_W-1:0] i_s_tdata,
    output logic                         o_m_tvalid,
    input  logic                         i_m_tready,
    // status, slot, free_slots, uncommitted, zero pad
    output logic [acl_rtm_pkg::OUT_W-1:0] o_m_tdata
);

    import acl_rtm_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FIN,
        S_POST
    } t_state;

    t_state                r_state;
    t_req                  w_req;
    t_action               r_act;
    logic [KEY_W-1:0]      r_key;
    logic [7:0]            r_ridx;
    logic [TABLE_DEPTH-1:0] r_valid;
    logic [CNT_W-1:0]      r_free;
    logic                  r_dirty;
    logic [CNT_W-1:0]      r_scan;
    logic                  r_cmp_vld;
    logic [IDX_W-1:0]      r_cmp_idx;
    logic                  r_hit;
    logic [IDX_W-1:0]      r_hit_idx;
    logic                  r_gap;
    logic [IDX_W-1:0]      r_gap_idx;
    t_status               r_st;
    logic [7:0]            r_slot;
    logic                  r_out_vld;
    t_rsp                  r_out;

    logic                  w_accept;
    logic                  w_issue;
    logic                  w_match_now;
    logic                  w_gap_now;
    logic                  w_scan_end;
    logic                  w_out_free;
    logic                  w_idx_in_range;
    logic [IDX_W-1:0]      w_idx;
    logic                  w_wr_en;
    logic [KEY_W-1:0]      w_rd_data;
    logic [KEY_W-1:0]      w_req_key;

    assign w_req      = t_req'(i_s_tdata);
    assign w_req_key  = {w_req.src_addr, w_req.dst_addr, w_req.src_prefix,
                         w_req.dst_prefix, w_req.port_low, w_req.port_high};
    assign o_s_tready = (r_state == S_IDLE);
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = r_out;
    assign w_out_free = !r_out_vld || i_m_tready;

    // scan: issue one read per cycle, compare the returned entry in the next cycle
    assign w_match_now = r_cmp_vld && r_valid[r_cmp_idx] && (w_rd_data == r_key);
    assign w_gap_now   = r_cmp_vld && !r_valid[r_cmp_idx];
    assign w_scan_end  = r_cmp_vld && (r_cmp_idx == IDX_W'(TABLE_DEPTH - 1));
    assign w_issue     = (r_state == S_SCAN) && (r_scan < CNT_W'(TABLE_DEPTH))
                         && !w_match_now;

    // delete by index lookup
    assign w_idx_in_range = (32'(r_ridx) < 32'(TABLE_DEPTH));
    assign w_idx          = IDX_W'(r_ridx);

    // new rule goes into the lowest free slot found by the walk
    assign w_wr_en = (r_state == S_FIN) && (r_act == ACT_ADD) && (r_free != '0)
                     && !r_hit && r_gap;

    acl_rtm_ram #(
        .WIDTH (KEY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_key_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_gap_idx),
        .i_wr_data (r_key),
        .i_rd_en   (w_issue),
        .i_rd_addr (r_scan[IDX_W-1:0]),
        .o_rd_data (w_rd_data)
    );

    // control state machine with table state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_valid   <= '0;
            r_free    <= CNT_W'(TABLE_DEPTH);
            r_dirty   <= 1'b0;
            r_cmp_vld <= 1'b0;
            r_hit     <= 1'b0;
            r_gap     <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_cmp_vld <= w_issue;
            r_cmp_idx <= r_scan[IDX_W-1:0];
            if (w_issue) begin
                r_scan <= r_scan + CNT_W'(1);
            end
            // output register drains when taken, reloaded in S_POST
            if (r_out_vld && i_m_tready && (r_state != S_POST)) begin
                r_out_vld <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    r_hit <= 1'b0;
                    r_gap <= 1'b0;
                    r_scan <= '0;
                    if (w_accept) begin
                        r_act  <= w_req.action;
                        r_key  <= w_req_key;
                        r_ridx <= w_req.rule_index;
                        if ((w_req.action == ACT_ADD && r_free != '0) ||
                            (w_req.action == ACT_DEL_MATCH &&
                             r_free != CNT_W'(TABLE_DEPTH))) begin
                            r_state <= S_SCAN;
                        end else begin
                            r_state <= S_FIN;
                        end
                    end
                end
                S_SCAN: begin
                    if (w_gap_now && !r_gap) begin
                        r_gap     <= 1'b1;
                        r_gap_idx <= r_cmp_idx;
                    end
                    if (w_match_now) begin
                        r_hit     <= 1'b1;
                        r_hit_idx <= r_cmp_idx;
                        r_state   <= S_FIN;
                    end else if (w_scan_end) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    r_state <= S_POST;
                    case (r_act)
                        ACT_ADD: begin
                            if (r_free == '0) begin
                                r_st   <= ST_FULL;
                                r_slot <= '0;
                            end else if (r_hit) begin
                                r_st   <= ST_EXISTS;
                                r_slot <= '0;
                            end else if (!r_gap) begin
                                r_st   <= ST_FULL;
                                r_slot <= '0;
                            end else begin
                                r_valid[r_gap_idx] <= 1'b1;
                                r_free  <= r_free - CNT_W'(1);
                                r_dirty <= 1'b1;
                                r_st    <= ST_OK;
                                r_slot  <= 8'(r_gap_idx);
                            end
                        end
                        ACT_DEL_MATCH: begin
                            if (r_hit) begin
                                r_valid[r_hit_idx] <= 1'b0;
                                r_free  <= r_free + CNT_W'(1);
                                r_dirty <= 1'b1;
                                r_st    <= ST_OK;
                                r_slot  <= 8'(r_hit_idx);
                            end else begin
                                r_st   <= ST_NOT_FOUND;
                                r_slot <= '0;
                            end
                        end
                        ACT_DEL_INDEX: begin
                            if (r_free == CNT_W'(TABLE_DEPTH) || !w_idx_in_range ||
                                !r_valid[w_idx]) begin
                                r_st   <= ST_NOT_FOUND;
                                r_slot <= '0;
                            end else begin
                                r_valid[w_idx] <= 1'b0;
                                r_free  <= r_free + CNT_W'(1);
                                r_dirty <= 1'b1;
                                r_st    <= ST_OK;
                                r_slot  <= r_ridx;
                            end
                        end
                        default: begin
                            r_valid <= '0;
                            r_free  <= CNT_W'(TABLE_DEPTH);
                            r_dirty <= 1'b1;
                            r_st    <= ST_OK;
                            r_slot  <= '0;
                        end
                    endcase
                end
                S_POST: begin
                    if (w_out_free) begin
                        r_out_vld         <= 1'b1;
                        r_out.pad         <= '0;
                        r_out.uncommitted <= r_dirty;
                        r_out.free_slots  <= 9'(r_free);
                        r_out.slot        <= r_slot;
                        r_out.status      <= r_st;
                        r_state           <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== src/acl_rtm_chk.sv =====
// port-level checker for the acl rule table manager and its bind
module acl_rtm_chk (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_s_tvalid,
    input logic                          o_s_tready,
    input logic [acl_rtm_pkg::IN_W-1:0]  i_s_tdata,
    input logic                          o_m_tvalid,
    input logic                          i_m_tready,
    input logic [acl_rtm_pkg::OUT_W-1:0] o_m_tdata
);

    import acl_rtm_pkg::*;

    t_rsp w_rsp;
    assign w_rsp = t_rsp'(o_m_tdata);

    // a stalled response beat holds its payload
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("response beat changed while stalled");

    // failed actions report slot zero
    a_fail_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && w_rsp.status != ST_OK |-> w_rsp.slot == 8'd0)
        else $error("nonzero slot on failed action");

    // a successful action always marks the table uncommitted
    a_ok_dirty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && w_rsp.status == ST_OK |-> w_rsp.uncommitted)
        else $error("successful action left uncommitted clear");

    // table full is reported only with no free slot left
    a_full_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && w_rsp.status == ST_FULL |-> w_rsp.free_slots == 9'd0)
        else $error("table full reported with free slots");

endmodule

bind acl_rule_table_manager_top acl_rtm_chk u_acl_rtm_chk (.*);
